FILE: rtl/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// shared types and constants of the indexed shift list: request codes,
// per-cell shift commands, control states and read-out grouping
// ----------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

  // default number of list entries
  localparam int unsigned ListDepthDefault = 128;

  // widths fixed by the request and result fields
  localparam int unsigned ModeW  = 3;
  localparam int unsigned PosW   = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 8;

  // cells gathered by one leaf of the registered read-out tree
  localparam int unsigned RdGroup = 16;

  // request codes
  typedef enum logic [ModeW-1:0] {
    MODE_INS_POS   = 3'd0,
    MODE_INS_FRONT = 3'd1,
    MODE_INS_BACK  = 3'd2,
    MODE_DEL_POS   = 3'd3,
    MODE_DEL_FRONT = 3'd4,
    MODE_DEL_BACK  = 3'd5,
    MODE_READ      = 3'd6
  } mode_e;

  // what every cell does with its word
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [WordW-1:0]  value;
  } cell_cmd_t;

  // control states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_MERGE  = 3'b100
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/isl_cell.sv
// ----------------------------------------------------------------------------
// isl_cell
// one list slot: holds a word, takes the left neighbor's on an insert below
// its slot, the new value on an insert at it, the right neighbor's on a delete
// at or below it, and drives its word onto the read-out tree when selected
// ----------------------------------------------------------------------------
`default_nettype none

module isl_cell import isl_pkg::*; #(
  parameter int unsigned SLOT_W   = 9,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                     clk_i,
  input  wire cell_cmd_t                cmd_i,
  input  wire logic [SLOT_W-1:0]        slot_i,
  input  wire logic signed [WordW-1:0]  left_i,
  input  wire logic signed [WordW-1:0]  right_i,
  input  wire logic                     rd_en_i,
  input  wire logic [SLOT_W-1:0]        rd_slot_i,
  output logic signed [WordW-1:0]       word_o,
  output logic signed [WordW-1:0]       rd_word_o
);

  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(CELL_IDX);

  logic signed [WordW-1:0] word_q, word_d;

  // next word from the shift command
  always_comb begin
    word_d = word_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (MyIdx > slot_i) begin
          word_d = left_i;
        end else if (MyIdx == slot_i) begin
          word_d = cmd_i.value;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= slot_i) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = (rd_en_i && (rd_slot_i == MyIdx)) ? word_q : '0;

endmodule

`default_nettype wire

FILE: rtl/indexed_shift_list_core.sv
// ----------------------------------------------------------------------------
// indexed_shift_list_core
// bounded ordered list of signed 32-bit words with 1-based positions
// ----------------------------------------------------------------------------
// usage:
//   requests come in on the input channel (in_valid_i / in_ready_o) with
//   mode_i, position_i and value_i; one result leaves on the output channel
//   (out_valid_o / out_ready_i) with ok_o, read_value_o, list_length_o and
//   is_empty_o. the list is a row of cells, one word each; an insert or a
//   delete moves every affected cell in the cycle the item is accepted.
//   a read goes through a registered two-level OR tree (groups of 16 cells,
//   then across groups): the slot is registered when the item is accepted,
//   the group ORs in the gather state and the result in the merge state.
//   one item is in flight at a time; a new item is taken in the cycle its
//   predecessor's result is taken. a stalled receiver holds the result in
//   the output register and the block takes no new item until it is taken.
//   reset empties the list (length zero) and drops any item in flight;
//   words are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_shift_list_core import isl_pkg::*; #(
  parameter int unsigned LIST_DEPTH = ListDepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [ModeW-1:0]         mode_i,
  input  wire logic [PosW-1:0]          position_i,
  input  wire logic signed [WordW-1:0]  value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          ok_o,
  output logic signed [WordW-1:0]       read_value_o,
  output logic [LenW-1:0]               list_length_o,
  output logic                          is_empty_o
);

  localparam int unsigned CntW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SlotW  = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam int unsigned NumGrp = (LIST_DEPTH + RdGroup - 1) / RdGroup;
  localparam logic [CntW-1:0] DepthCnt = CntW'(LIST_DEPTH);

  state_e state_q, state_d;

  logic [CntW-1:0]  count_q, count_d;
  logic             ok_q, ok_d;
  logic             rd_en_q, rd_en_d;
  logic [SlotW-1:0] rd_slot_q, rd_slot_d;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] pos_ext, cnt_ext;
  logic             full, in_fire;
  cell_cmd_t        cmd, cell_cmd;

  logic signed [WordW-1:0] words [LIST_DEPTH];
  logic signed [WordW-1:0] rd_words [LIST_DEPTH];
  logic signed [WordW-1:0] grp_q [NumGrp];
  logic signed [WordW-1:0] grp_d [NumGrp];
  logic signed [WordW-1:0] merge;

  logic                    out_valid_q;
  logic                    out_ok_q;
  logic signed [WordW-1:0] out_value_q;
  logic [CntW-1:0]         out_cnt_q;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_ext = SlotW'(position_i);
  assign cnt_ext = SlotW'(count_q);
  assign full    = (count_q == DepthCnt);

  // request decode: acceptance check, shift command, new length
  always_comb begin
    ok_d      = 1'b0;
    rd_en_d   = 1'b0;
    rd_slot_d = pos_ext - SlotW'(1);
    count_d   = count_q;
    cmd.op    = CELL_HOLD;
    cmd.value = value_i;
    slot      = '0;
    case (mode_e'(mode_i))
      MODE_INS_POS: begin
        if (!full && (pos_ext != '0) && (pos_ext <= cnt_ext + SlotW'(1))) begin
          ok_d    = 1'b1;
          cmd.op  = CELL_INS;
          slot    = pos_ext - SlotW'(1);
          count_d = count_q + CntW'(1);
        end
      end
      MODE_INS_FRONT: begin
        if (!full) begin
          ok_d    = 1'b1;
          cmd.op  = CELL_INS;
          count_d = count_q + CntW'(1);
        end
      end
      MODE_INS_BACK: begin
        if (!full) begin
          ok_d    = 1'b1;
          cmd.op  = CELL_INS;
          slot    = cnt_ext;
          count_d = count_q + CntW'(1);
        end
      end
      MODE_DEL_POS: begin
        if ((pos_ext != '0) && (pos_ext <= cnt_ext)) begin
          ok_d    = 1'b1;
          cmd.op  = CELL_DEL;
          slot    = pos_ext - SlotW'(1);
          count_d = count_q - CntW'(1);
        end
      end
      MODE_DEL_FRONT: begin
        if (count_q != '0) begin
          ok_d    = 1'b1;
          cmd.op  = CELL_DEL;
          count_d = count_q - CntW'(1);
        end
      end
      MODE_DEL_BACK: begin
        if (count_q != '0) begin
          ok_d    = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      MODE_READ: begin
        if ((pos_ext != '0) && (pos_ext <= cnt_ext)) begin
          ok_d    = 1'b1;
          rd_en_d = 1'b1;
        end
      end
      default: ok_d = 1'b0;
    endcase
  end

  // cells move only on an accepted item
  always_comb begin
    cell_cmd    = cmd;
    cell_cmd.op = in_fire ? cmd.op : CELL_HOLD;
  end

  // row of cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [WordW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = words[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = words[i+1];
    end
    isl_cell #(
      .SLOT_W   (SlotW),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cell_cmd),
      .slot_i    (slot),
      .left_i    (left),
      .right_i   (right),
      .rd_en_i   (rd_en_q),
      .rd_slot_i (rd_slot_q),
      .word_o    (words[i]),
      .rd_word_o (rd_words[i])
    );
  end

  // first level of the read-out tree: OR within each group
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < RdGroup; j++) begin
        if (g * RdGroup + j < LIST_DEPTH) begin
          grp_d[g] = grp_d[g] | rd_words[g * RdGroup + j];
        end
      end
    end
  end

  // second level: OR across groups
  always_comb begin
    merge = '0;
    for (int g = 0; g < NumGrp; g++) begin
      merge = merge | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_GATHER) begin
      grp_q <= grp_d;
    end
  end

  // sequencing of one item
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_GATHER;
      ST_GATHER: state_d = ST_MERGE;
      ST_MERGE:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        count_q <= count_d;
      end
      if (state_q == ST_MERGE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload carried to the output
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q      <= ok_d;
      rd_en_q   <= rd_en_d;
      rd_slot_q <= rd_slot_d;
    end
    if (state_q == ST_MERGE) begin
      out_ok_q    <= ok_q;
      out_value_q <= merge;
      out_cnt_q   <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign read_value_o  = out_value_q;
  assign list_length_o = LenW'(out_cnt_q);
  assign is_empty_o    = (out_cnt_q == '0);

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count above list depth");

  a_fire_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_GATHER))
    else $error("accepted item did not start read-out");

  a_merge_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |=> out_valid_q)
    else $error("result not presented after merge");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_value_q == '0))
    else $error("rejected item carries a read value");

endmodule

`default_nettype wire
